// ===== hw/rtl/awsc_pkg.sv =====
// shared types and constants of the affine warp source coordinate unit
package awsc_pkg;

	localparam int FIELD_BITS   = 16;
	localparam int COEF_BITS    = 32;
	localparam int SIZE_BITS    = 64;
	localparam int CFG_IDX_BITS = 3;

	localparam logic [CFG_IDX_BITS-1:0] REG_COEF_XX     = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_COEF_XY     = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_OFFSET_X    = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_COEF_YX     = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_COEF_YY     = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_OFFSET_Y    = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_SIZES = 3'd6;
	localparam logic [CFG_IDX_BITS-1:0] REG_ROI_WINDOW  = 3'd7;

	localparam logic [COEF_BITS-1:0] COEF_ONE  = 32'h0001_0000;
	localparam logic [COEF_BITS-1:0] COEF_ZERO = 32'h0000_0000;

	typedef struct packed {
		logic [COEF_BITS-1:0] coef_xx;
		logic [COEF_BITS-1:0] coef_xy;
		logic [COEF_BITS-1:0] offset_x;
		logic [COEF_BITS-1:0] coef_yx;
		logic [COEF_BITS-1:0] coef_yy;
		logic [COEF_BITS-1:0] offset_y;
		logic [SIZE_BITS-1:0] image_sizes;
		logic [SIZE_BITS-1:0] roi_window;
	} cfg_t;

	typedef struct packed {
		logic en_s2;
		logic en_s3;
		logic en_s4;
	} pipe_ctrl_t;

endpackage

// ===== hw/rtl/awsc_ifs.sv =====
// channel interfaces: destination coordinates in, source coordinates out, register writes
interface awsc_in_if;
	logic                            valid;
	logic                            ready;
	logic [awsc_pkg::FIELD_BITS-1:0] dest_x;
	logic [awsc_pkg::FIELD_BITS-1:0] dest_y;

	modport source (output valid, output dest_x, output dest_y, input ready);
	modport sink (input valid, input dest_x, input dest_y, output ready);
endinterface

interface awsc_out_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [awsc_pkg::COEF_BITS-1:0]  src_x;
	logic signed [awsc_pkg::COEF_BITS-1:0]  src_y;
	logic                                   inside_res;
	logic [awsc_pkg::FIELD_BITS-1:0]        out_x;
	logic [awsc_pkg::FIELD_BITS-1:0]        out_y;

	modport source (output valid, output src_x, output src_y, output inside_res,
		output out_x, output out_y, input ready);
	modport sink (input valid, input src_x, input src_y, input inside_res,
		input out_x, input out_y, output ready);
endinterface

interface awsc_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [awsc_pkg::CFG_IDX_BITS-1:0] index;
	logic [awsc_pkg::SIZE_BITS-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/awsc_cfg_regs.sv =====
// configuration register file
module awsc_cfg_regs (
	input  logic                clk,
	input  logic                arst_n,
	awsc_cfg_if.sink            cfg,
	output awsc_pkg::cfg_t      regs
);

	awsc_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.coef_xx     <= awsc_pkg::COEF_ONE;
			regs_q.coef_xy     <= awsc_pkg::COEF_ZERO;
			regs_q.offset_x    <= awsc_pkg::COEF_ZERO;
			regs_q.coef_yx     <= awsc_pkg::COEF_ZERO;
			regs_q.coef_yy     <= awsc_pkg::COEF_ONE;
			regs_q.offset_y    <= awsc_pkg::COEF_ZERO;
			regs_q.image_sizes <= '0;
			regs_q.roi_window  <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				awsc_pkg::REG_COEF_XX:     regs_q.coef_xx     <= cfg.data[awsc_pkg::COEF_BITS-1:0];
				awsc_pkg::REG_COEF_XY:     regs_q.coef_xy     <= cfg.data[awsc_pkg::COEF_BITS-1:0];
				awsc_pkg::REG_OFFSET_X:    regs_q.offset_x    <= cfg.data[awsc_pkg::COEF_BITS-1:0];
				awsc_pkg::REG_COEF_YX:     regs_q.coef_yx     <= cfg.data[awsc_pkg::COEF_BITS-1:0];
				awsc_pkg::REG_COEF_YY:     regs_q.coef_yy     <= cfg.data[awsc_pkg::COEF_BITS-1:0];
				awsc_pkg::REG_OFFSET_Y:    regs_q.offset_y    <= cfg.data[awsc_pkg::COEF_BITS-1:0];
				awsc_pkg::REG_IMAGE_SIZES: regs_q.image_sizes <= cfg.data;
				awsc_pkg::REG_ROI_WINDOW:  regs_q.roi_window  <= cfg.data;
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/awsc_coord_map.sv =====
// one source coordinate: products, truncated linear sum, translation, recentering, saturation
module awsc_coord_map #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 16
) (
	input  logic                                  clk,
	input  awsc_pkg::pipe_ctrl_t                  ctrl,
	input  logic signed [awsc_pkg::COEF_BITS-1:0] coef_a,
	input  logic signed [awsc_pkg::COEF_BITS-1:0] coef_b,
	input  logic signed [awsc_pkg::COEF_BITS-1:0] offset,
	input  logic signed [COORD_BITS:0]            cx,
	input  logic signed [COORD_BITS:0]            cy,
	input  logic [COORD_BITS-2:0]                 half_src,
	output logic signed [awsc_pkg::COEF_BITS-1:0] src_s4
);

	localparam int CB  = awsc_pkg::COEF_BITS;
	localparam int CW  = COORD_BITS + 1;
	localparam int PW  = CB + CW;
	localparam int LW  = PW + 1;
	localparam int TW  = LW - FRAC_BITS + 1;
	localparam int AW  = TW + 1;
	localparam int RW  = (AW + 1 > CB + 1) ? AW + 1 : CB + 1;
	localparam int OIW = CB - FRAC_BITS;

	logic signed [PW-1:0]  prod_a_s2;
	logic signed [PW-1:0]  prod_b_s2;
	logic signed [LW-1:0]  lin;
	logic signed [LW-1:0]  lin_sh;
	logic                  lin_corr;
	logic signed [TW-1:0]  t1;
	logic signed [TW-1:0]  t1_s3;
	logic signed [OIW-1:0] off_int;
	logic                  off_frac_nz;
	logic signed [AW-1:0]  s_int;
	logic signed [AW-1:0]  t2;
	logic [RW-1:0]         r;
	logic [RW-1:0]         sat_hi;
	logic signed [CB-1:0]  src;

	always_ff @(posedge clk) begin
		if (ctrl.en_s2) begin
			prod_a_s2 <= coef_a * cx;
			prod_b_s2 <= coef_b * cy;
		end
	end

	// truncation toward zero of the linear part
	always_comb begin
		lin      = {prod_a_s2[PW-1], prod_a_s2} + {prod_b_s2[PW-1], prod_b_s2};
		lin_sh   = lin >>> FRAC_BITS;
		lin_corr = lin[LW-1] && (|lin[FRAC_BITS-1:0]);
		t1       = lin_sh[TW-1:0] + TW'(lin_corr);
	end

	always_ff @(posedge clk) begin
		if (ctrl.en_s3) begin
			t1_s3 <= t1;
		end
	end

	// translation with second truncation, then recentering and saturation
	always_comb begin
		off_int     = offset[CB-1:FRAC_BITS];
		off_frac_nz = |offset[FRAC_BITS-1:0];
		s_int       = {t1_s3[TW-1], t1_s3} + {{(AW-OIW){off_int[OIW-1]}}, off_int};
		t2          = s_int + AW'(s_int[AW-1] && off_frac_nz);
		r           = {{(RW-AW){t2[AW-1]}}, t2} + RW'(half_src);
		sat_hi      = r >> (CB - 1);
		if (sat_hi == '0 || sat_hi == (RW'(1) << (RW - CB + 1)) - RW'(1)) begin
			src = r[CB-1:0];
		end else if (r[RW-1]) begin
			src = {1'b1, {(CB-1){1'b0}}};
		end else begin
			src = {1'b0, {(CB-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en_s4) begin
			src_s4 <= src;
		end
	end

endmodule

// ===== hw/rtl/affine_warp_source_coordinate_unit.sv =====
// Affine warp source coordinate unit: maps each destination pixel (dest_x, dest_y) through a
// 2x3 signed fixed-point matrix, centered on half the destination size and recentered on half
// the source size, giving the saturated source coordinate, an inside-window flag and the
// destination coordinate echoed back. One transaction is accepted every clock unless the
// pipeline is stalled; each result passes in turn through the input register, the registered
// 32x17 products, the truncated linear sum, the translated and saturated coordinate and the
// output register with the window test. Backpressure on the output stalls only the stages
// that hold data, so empty stages keep taking new transactions. Register writes take effect
// on the next cycle and are to be made only while no transaction is in flight.
module affine_warp_source_coordinate_unit #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	awsc_cfg_if.sink   cfg,
	awsc_in_if.sink    pix_in,
	awsc_out_if.source pix_out
);

	localparam int FB = awsc_pkg::FIELD_BITS;
	localparam int CB = awsc_pkg::COEF_BITS;

	awsc_pkg::cfg_t       regs;
	awsc_pkg::pipe_ctrl_t ctrl;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	logic [COORD_BITS-1:0] dx_s1, dy_s1, dx_s2, dy_s2, dx_s3, dy_s3, dx_s4, dy_s4;
	logic [COORD_BITS-1:0] src_w, src_h, dst_w, dst_h;
	logic [COORD_BITS-1:0] xb, xe, yb, ye;
	logic signed [COORD_BITS:0] cx, cy;
	logic signed [CB-1:0] src_x_s4, src_y_s4;
	logic signed [CB-1:0] src_x_s5, src_y_s5;
	logic                 inside_s5;
	logic [FB-1:0]        out_x_s5, out_y_s5;
	logic                 in_window;

	awsc_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// per-stage flow control
	assign rdy5 = !v_s5 || pix_out.ready;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;

	assign pix_in.ready = rdy1;
	assign ctrl.en_s2   = rdy2;
	assign ctrl.en_s3   = rdy3;
	assign ctrl.en_s4   = rdy4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= pix_in.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			dx_s1 <= pix_in.dest_x[COORD_BITS-1:0];
			dy_s1 <= pix_in.dest_y[COORD_BITS-1:0];
		end
		if (rdy2) begin
			dx_s2 <= dx_s1;
			dy_s2 <= dy_s1;
		end
		if (rdy3) begin
			dx_s3 <= dx_s2;
			dy_s3 <= dy_s2;
		end
		if (rdy4) begin
			dx_s4 <= dx_s3;
			dy_s4 <= dy_s3;
		end
	end

	// packed size and window fields
	assign src_w = regs.image_sizes[48 +: COORD_BITS];
	assign src_h = regs.image_sizes[32 +: COORD_BITS];
	assign dst_w = regs.image_sizes[16 +: COORD_BITS];
	assign dst_h = regs.image_sizes[0 +: COORD_BITS];
	assign xb    = regs.roi_window[48 +: COORD_BITS];
	assign xe    = regs.roi_window[32 +: COORD_BITS];
	assign yb    = regs.roi_window[16 +: COORD_BITS];
	assign ye    = regs.roi_window[0 +: COORD_BITS];

	assign cx = $signed({1'b0, dx_s1}) - $signed({2'b00, dst_w[COORD_BITS-1:1]});
	assign cy = $signed({1'b0, dy_s1}) - $signed({2'b00, dst_h[COORD_BITS-1:1]});

	awsc_coord_map #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_map_x (
		.clk      (clk),
		.ctrl     (ctrl),
		.coef_a   (regs.coef_xx),
		.coef_b   (regs.coef_xy),
		.offset   (regs.offset_x),
		.cx       (cx),
		.cy       (cy),
		.half_src (src_w[COORD_BITS-1:1]),
		.src_s4   (src_x_s4)
	);

	awsc_coord_map #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_map_y (
		.clk      (clk),
		.ctrl     (ctrl),
		.coef_a   (regs.coef_yx),
		.coef_b   (regs.coef_yy),
		.offset   (regs.offset_y),
		.cx       (cx),
		.cy       (cy),
		.half_src (src_h[COORD_BITS-1:1]),
		.src_s4   (src_y_s4)
	);

	// window test, negative coordinates never inside
	assign in_window = !src_x_s4[CB-1] && !src_y_s4[CB-1]
		&& (src_x_s4[CB-2:0] >= (CB-1)'(xb)) && (src_x_s4[CB-2:0] < (CB-1)'(xe))
		&& (src_y_s4[CB-2:0] >= (CB-1)'(yb)) && (src_y_s4[CB-2:0] < (CB-1)'(ye));

	always_ff @(posedge clk) begin
		if (rdy5) begin
			src_x_s5  <= src_x_s4;
			src_y_s5  <= src_y_s4;
			inside_s5 <= in_window;
			out_x_s5  <= FB'(dx_s4);
			out_y_s5  <= FB'(dy_s4);
		end
	end

	assign pix_out.valid      = v_s5;
	assign pix_out.src_x      = src_x_s5;
	assign pix_out.src_y      = src_y_s5;
	assign pix_out.inside_res = inside_s5;
	assign pix_out.out_x      = out_x_s5;
	assign pix_out.out_y      = out_y_s5;

endmodule
